// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/vtpd_pkg.sv -----
// ----------------------------------------------------------------------------
// vtpd_pkg
// constants and codes for the valve time proportioning driver
// ----------------------------------------------------------------------------
package vtpd_pkg;

	localparam int TIME_W = 24;

	localparam logic [7:0] LEVEL_MAX    = 8'd200;
	localparam logic [7:0] LEVEL_HALF   = 8'd100;
	localparam logic [7:0] DEFAULT_ERR  = 8'd30;
	localparam logic [7:0] DEFAULT_SW   = 8'd18;
	localparam logic [7:0] UNSET_CODE   = 8'hFF;
	localparam logic [TIME_W-1:0] PERIOD_UNIT = 24'd10000;
	localparam logic [TIME_W-1:0] ON_UNIT     = 24'd50;
	localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};

	// mode codes carried in command_value
	localparam logic [7:0] CODE_TOGGLE = 8'd201;
	localparam logic [7:0] CODE_MANUAL = 8'd203;
	localparam logic [7:0] CODE_AUTO   = 8'd205;

	// request kinds
	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_SET  = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SWITCH_TIME   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_POS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_UNLOCKED      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NON_INVERTED  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_INDEX = 3'd4;

endpackage

// ----- rtl/vtpd_req_if.sv -----
// ----------------------------------------------------------------------------
// vtpd_req_if
// request channel: millisecond ticks and set commands
// ----------------------------------------------------------------------------
interface vtpd_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] command_value;
	logic       by_pid;

	modport source (output valid, req_type, command_value, by_pid, input ready);
	modport sink   (input valid, req_type, command_value, by_pid, output ready);
endinterface

// ----- rtl/vtpd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// vtpd_rsp_if
// result channel: valve drive and status after each request
// ----------------------------------------------------------------------------
interface vtpd_rsp_if;
	logic       valid;
	logic       ready;
	logic       drive_out;
	logic [7:0] level_out;
	logic       auto_out;
	logic       opening_out;

	modport source (output valid, drive_out, level_out, auto_out, opening_out, input ready);
	modport sink   (input valid, drive_out, level_out, auto_out, opening_out, output ready);
endinterface

// ----- rtl/valve_time_proportioning_driver_unit.sv -----
// ----------------------------------------------------------------------------
// valve_time_proportioning_driver_unit
// slow pwm drive for one thermal valve channel, with manual and auto modes
// ----------------------------------------------------------------------------
//  channel  dir  word
//  req      in   req_type, command_value, by_pid
//  rsp      out  drive_out, level_out, auto_out, opening_out
//  cfg      in   cfg_wr_en, cfg_index, cfg_data (write only)
//
//  one word per clock while results are taken; a request is held in the input
//  register and its result is registered in the valve state registers.
//  the valve state registers double as the result register, so a stalled
//  result holds the state; the input register holds one more word and then
//  drops ready until the result is taken.
//  arst_n clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module valve_time_proportioning_driver_unit #(
	parameter int STARTUP_DELAY_MS = 1000
) (
	input  logic                            clk,
	input  logic                            arst_n,
	vtpd_req_if.sink                        req,
	vtpd_rsp_if.source                      rsp,
	input  logic                            cfg_wr_en,
	input  logic [vtpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [7:0]                      cfg_data
);

	localparam int TW = vtpd_pkg::TIME_W;

	// configuration registers
	logic [7:0] switch_time_q;
	logic [7:0] error_pos_q;
	logic       unlocked_q;
	logic       non_inverted_q;
	logic [2:0] channel_index_q;

	// input stage
	logic       valid_s1;
	logic       req_type_s1;
	logic [7:0] command_value_s1;
	logic       by_pid_s1;

	// valve state, also the result word
	logic          rsp_valid_q;
	logic [7:0]    level_q;
	logic          rising_q;
	logic          auto_q;
	logic          drive_q;
	logic          first_q;
	logic          next_on_q;
	logic          startup_q;
	logic [TW-1:0] elapsed_q;
	logic [TW-1:0] phase_delay_q;

	// next state
	logic [7:0]    level_d;
	logic          rising_d;
	logic          auto_d;
	logic          drive_d;
	logic          first_d;
	logic          next_on_d;
	logic          startup_d;
	logic [TW-1:0] elapsed_d;
	logic [TW-1:0] phase_delay_d;

	logic          adv;
	logic          do_switch;
	logic [7:0]    eff_sw;
	logic [7:0]    eff_err;
	logic [15:0]   sw_level;
	logic [TW-1:0] on_t;
	logic [TW-1:0] off_t;
	logic [TW-1:0] period_t;
	logic [TW-1:0] switch_delay;
	logic [TW-1:0] startup_delay;
	logic [TW-1:0] cur_delay;
	logic [TW-1:0] elapsed_inc;
	logic [7:0]    target;
	logic          take_cmd;

	// handshake
	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_time_q   <= vtpd_pkg::DEFAULT_SW;
			error_pos_q     <= vtpd_pkg::DEFAULT_ERR;
			unlocked_q      <= 1'b1;
			non_inverted_q  <= 1'b1;
			channel_index_q <= 3'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				vtpd_pkg::REG_SWITCH_TIME:   switch_time_q   <= cfg_data;
				vtpd_pkg::REG_ERROR_POS:     error_pos_q     <= cfg_data;
				vtpd_pkg::REG_UNLOCKED:      unlocked_q      <= cfg_data[0];
				vtpd_pkg::REG_NON_INVERTED:  non_inverted_q  <= cfg_data[0];
				vtpd_pkg::REG_CHANNEL_INDEX: channel_index_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// effective settings
	assign eff_sw = (switch_time_q == 8'd0 || switch_time_q == vtpd_pkg::UNSET_CODE)
		? vtpd_pkg::DEFAULT_SW : switch_time_q;
	assign eff_err = (error_pos_q == vtpd_pkg::UNSET_CODE) ? vtpd_pkg::DEFAULT_ERR
		: (error_pos_q > vtpd_pkg::LEVEL_MAX) ? vtpd_pkg::LEVEL_MAX : error_pos_q;
	assign startup_delay = TW'(STARTUP_DELAY_MS) * (TW'(channel_index_q) + TW'(1));

	// phase lengths for the current level
	assign sw_level     = 16'(eff_sw) * 16'(level_q);
	assign on_t         = TW'(sw_level) * vtpd_pkg::ON_UNIT;
	assign period_t     = TW'(eff_sw) * vtpd_pkg::PERIOD_UNIT;
	assign off_t        = period_t - on_t;
	assign switch_delay = first_q ? ((on_t >= off_t) ? (on_t >> 1) : (off_t >> 1))
		: (next_on_q ? on_t : off_t);

	// tick timing
	assign cur_delay   = startup_q ? startup_delay : phase_delay_q;
	assign elapsed_inc = (elapsed_q == vtpd_pkg::TIME_MAX) ? elapsed_q : elapsed_q + TW'(1);
	assign do_switch   = (req_type_s1 == vtpd_pkg::REQ_TICK) && (elapsed_inc >= cur_delay);
	assign take_cmd    = (req_type_s1 == vtpd_pkg::REQ_SET) && (unlocked_q || by_pid_s1);

	// next valve state
	always_comb begin
		level_d       = level_q;
		rising_d      = rising_q;
		auto_d        = auto_q;
		drive_d       = drive_q;
		first_d       = first_q;
		next_on_d     = next_on_q;
		startup_d     = startup_q;
		elapsed_d     = elapsed_q;
		phase_delay_d = phase_delay_q;
		target        = level_q;
		if (req_type_s1 == vtpd_pkg::REQ_TICK) begin
			if (do_switch) begin
				drive_d       = next_on_q ? non_inverted_q : !non_inverted_q;
				next_on_d     = !next_on_q;
				first_d       = 1'b0;
				startup_d     = 1'b0;
				phase_delay_d = switch_delay;
				elapsed_d     = '0;
			end else begin
				elapsed_d     = elapsed_inc;
				phase_delay_d = cur_delay;
			end
		end else if (take_cmd) begin
			if (command_value_s1 <= vtpd_pkg::LEVEL_MAX && (!auto_q || by_pid_s1)) begin
				target = command_value_s1;
			end else begin
				priority if (command_value_s1 == vtpd_pkg::CODE_TOGGLE) auto_d = !auto_q;
				else if (command_value_s1 == vtpd_pkg::CODE_AUTO)        auto_d = 1'b1;
				else if (command_value_s1 == vtpd_pkg::CODE_MANUAL)      auto_d = 1'b0;
				else                                                     auto_d = auto_q;
				target = auto_d ? eff_err : level_q;
			end
			// a new level restarts the phase pattern at the next switch
			if (target != level_q) begin
				rising_d  = level_q < target;
				level_d   = target;
				first_d   = 1'b1;
				next_on_d = target >= vtpd_pkg::LEVEL_HALF;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1      <= req.req_type;
			command_value_s1 <= req.command_value;
			by_pid_s1        <= req.by_pid;
		end
	end

	// valve state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q   <= 1'b0;
			level_q       <= vtpd_pkg::DEFAULT_ERR;
			rising_q      <= 1'b0;
			auto_q        <= 1'b0;
			drive_q       <= 1'b0;
			first_q       <= 1'b1;
			next_on_q     <= 1'b0;
			startup_q     <= 1'b1;
			elapsed_q     <= '0;
			phase_delay_q <= TW'(STARTUP_DELAY_MS);
		end else begin
			if (adv) begin
				rsp_valid_q   <= 1'b1;
				level_q       <= level_d;
				rising_q      <= rising_d;
				auto_q        <= auto_d;
				drive_q       <= drive_d;
				first_q       <= first_d;
				next_on_q     <= next_on_d;
				startup_q     <= startup_d;
				elapsed_q     <= elapsed_d;
				phase_delay_q <= phase_delay_d;
			end else if (rsp.ready) begin
				rsp_valid_q   <= 1'b0;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.drive_out   = drive_q;
	assign rsp.level_out   = level_q;
	assign rsp.auto_out    = auto_q;
	assign rsp.opening_out = rising_q;

	// checks
	`ASSERT_SAME(a_level_range, clk, arst_n, rsp_valid_q, level_q <= vtpd_pkg::LEVEL_MAX, "level above maximum")
	`ASSERT_NEXT(a_drive_only_on_switch, clk, arst_n, !(adv && do_switch), $stable(drive_q), "drive changed without a phase switch")
	`ASSERT_NEXT(a_startup_once, clk, arst_n, !startup_q, !startup_q, "startup re-entered")

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the valve time proportioning driver. Ticks and set
// commands go in on the request channel, one status word comes back for
// each. A local model of the valve predicts every status word. Covered: mode
// codes, lock and pid bypass, error position defaults, startup delay and
// the first phase switch after reset for each level and polarity.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int          CLK_PERIOD   = 2;
	localparam int          RESET_CYCLES = 7;
	localparam int          STARTUP_MS   = 20;
	localparam int          DRAIN_CYCLES = 4;
	localparam int unsigned STALL_LIMIT  = 1000;

	typedef struct packed {
		logic       drive_out;
		logic [7:0] level_out;
		logic       auto_out;
		logic       opening_out;
	} valve_status_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [vtpd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0] cfg_data;
	logic snk_ready = 1'b0;

	vtpd_req_if req_ch ();
	vtpd_rsp_if rsp_ch ();

	assign rsp_ch.ready = snk_ready;

	valve_time_proportioning_driver_unit #(
		.STARTUP_DELAY_MS(STARTUP_MS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// expected status words, oldest first
	valve_status_t pending_status[$];
	int unsigned   words_sent;
	int unsigned   words_checked;
	int unsigned   mismatch_count;
	int            gap_pct;
	int            stall_pct;
	int            mix_phase;

	// register copies
	logic [7:0] cfg_switch;
	logic [7:0] cfg_err;
	logic       cfg_unlocked;
	logic       cfg_noninv;
	logic [2:0] cfg_chan;

	// valve model state
	logic [7:0]                  lvl;
	logic                        opening;
	logic                        auto_on;
	logic                        drive;
	logic                        first_phase;
	logic                        next_on;
	logic                        starting;
	logic [vtpd_pkg::TIME_W-1:0] elapsed;
	logic [vtpd_pkg::TIME_W-1:0] phase_len;

	function automatic logic [7:0] eff_switch_time();
		if (cfg_switch == 8'd0 || cfg_switch == vtpd_pkg::UNSET_CODE)
			return vtpd_pkg::DEFAULT_SW;
		return cfg_switch;
	endfunction

	function automatic logic [7:0] eff_error_pos();
		if (cfg_err == vtpd_pkg::UNSET_CODE) return vtpd_pkg::DEFAULT_ERR;
		return (cfg_err > vtpd_pkg::LEVEL_MAX) ? vtpd_pkg::LEVEL_MAX : cfg_err;
	endfunction

	function automatic logic [vtpd_pkg::TIME_W-1:0] startup_len();
		return vtpd_pkg::TIME_W'(STARTUP_MS * (int'(cfg_chan) + 1));
	endfunction

	function automatic void valve_reset();
		cfg_switch   = vtpd_pkg::DEFAULT_SW;
		cfg_err      = vtpd_pkg::DEFAULT_ERR;
		cfg_unlocked = 1'b1;
		cfg_noninv   = 1'b1;
		cfg_chan     = 3'd0;
		lvl          = vtpd_pkg::DEFAULT_ERR;
		opening      = 1'b0;
		auto_on      = 1'b0;
		drive        = 1'b0;
		first_phase  = 1'b1;
		next_on      = vtpd_pkg::DEFAULT_ERR >= vtpd_pkg::LEVEL_HALF;
		starting     = 1'b1;
		elapsed      = '0;
		phase_len    = startup_len();
	endfunction

	// a new level restarts the phase pattern with the longer phase first
	function automatic void set_level(logic [7:0] v);
		if (v == lvl) return;
		opening     = lvl < v;
		lvl         = v;
		first_phase = 1'b1;
		next_on     = v >= vtpd_pkg::LEVEL_HALF;
	endfunction

	// end of a phase: pick the next phase length and flip the drive
	function automatic void phase_switch();
		int unsigned sw;
		int unsigned on_t;
		int unsigned off_t;
		int unsigned d;
		sw    = eff_switch_time();
		on_t  = sw * vtpd_pkg::ON_UNIT * lvl;
		off_t = sw * vtpd_pkg::PERIOD_UNIT - on_t;
		if (first_phase)
			d = (on_t >= off_t) ? on_t / 2 : off_t / 2;
		else
			d = next_on ? on_t : off_t;
		drive       = next_on ? cfg_noninv : !cfg_noninv;
		next_on     = !next_on;
		first_phase = 1'b0;
		starting    = 1'b0;
		phase_len   = d[vtpd_pkg::TIME_W-1:0];
		elapsed     = '0;
	endfunction

	function automatic valve_status_t valve_step(logic rt, logic [7:0] v, logic pid);
		if (rt == vtpd_pkg::REQ_TICK) begin
			if (starting) phase_len = startup_len();
			if (elapsed != vtpd_pkg::TIME_MAX) elapsed++;
			if (elapsed >= phase_len) phase_switch();
		end else if (cfg_unlocked || pid) begin
			if (v <= vtpd_pkg::LEVEL_MAX && (!auto_on || pid)) begin
				set_level(v);
			end else begin
				if (v == vtpd_pkg::CODE_TOGGLE) auto_on = !auto_on;
				else if (v == vtpd_pkg::CODE_AUTO) auto_on = 1'b1;
				else if (v == vtpd_pkg::CODE_MANUAL) auto_on = 1'b0;
				set_level(auto_on ? eff_error_pos() : lvl);
			end
		end
		return '{drive, lvl, auto_on, opening};
	endfunction

	// result checking and prediction on accepted words
	always @(posedge clk) begin : scoreboard
		valve_status_t want;
		valve_status_t got;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.drive_out, rsp_ch.level_out, rsp_ch.auto_out,
					rsp_ch.opening_out};
				words_checked++;
				if (pending_status.size() == 0) begin
					$error("status word with no request pending");
					mismatch_count++;
				end else begin
					want = pending_status.pop_front();
					if (got.drive_out !== want.drive_out) begin
						$error("drive_out: expected %0d, got %0d", want.drive_out,
							got.drive_out);
						mismatch_count++;
					end
					if (got.level_out !== want.level_out) begin
						$error("level_out: expected %0d, got %0d", want.level_out,
							got.level_out);
						mismatch_count++;
					end
					if (got.auto_out !== want.auto_out) begin
						$error("auto_out: expected %0d, got %0d", want.auto_out,
							got.auto_out);
						mismatch_count++;
					end
					if (got.opening_out !== want.opening_out) begin
						$error("opening_out: expected %0d, got %0d", want.opening_out,
							got.opening_out);
						mismatch_count++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready)
				pending_status.push_back(valve_step(req_ch.req_type,
					req_ch.command_value, req_ch.by_pid));
		end
	end

	// result side backpressure in random bursts
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left--;
			snk_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < stall_pct) begin
			stall_left = $urandom_range(0, 7);
			snk_ready <= 1'b0;
		end else begin
			snk_ready <= 1'b1;
		end
	end

	// watchdog on cycles without any accepted word
	int unsigned quiet_cycles = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// one request word, with an optional idle burst before it
	task automatic send_word(logic rt, logic [7:0] v, logic pid);
		if ($urandom_range(0, 99) < gap_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.req_type      <= rt;
		req_ch.command_value <= v;
		req_ch.by_pid        <= pid;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		words_sent++;
	endtask

	task automatic tick_run(int n);
		repeat (n) send_word(vtpd_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
	endtask

	// wait until every status word is back and the pipe is empty
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (words_checked != words_sent) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// pulse the reset while idle and return the model to its reset state
	task automatic restart();
		drain();
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		valve_reset();
		@(posedge clk);
	endtask

	task automatic write_reg(logic [vtpd_pkg::CFG_IDX_W-1:0] idx, logic [7:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			vtpd_pkg::REG_SWITCH_TIME:   cfg_switch   = data;
			vtpd_pkg::REG_ERROR_POS:     cfg_err      = data;
			vtpd_pkg::REG_UNLOCKED:      cfg_unlocked = data[0];
			vtpd_pkg::REG_NON_INVERTED:  cfg_noninv   = data[0];
			vtpd_pkg::REG_CHANNEL_INDEX: cfg_chan     = data[2:0];
			default: ;
		endcase
	endtask

	// all registers plus one unused index, only while idle
	task automatic configure(logic [7:0] sw, logic [7:0] err, logic unl, logic ninv,
		logic [2:0] ch);
		drain();
		write_reg(vtpd_pkg::REG_SWITCH_TIME, sw);
		write_reg(vtpd_pkg::REG_ERROR_POS, err);
		write_reg(vtpd_pkg::REG_UNLOCKED, {7'($urandom), unl});
		write_reg(vtpd_pkg::REG_NON_INVERTED, {7'($urandom), ninv});
		write_reg(vtpd_pkg::REG_CHANNEL_INDEX, {5'($urandom), ch});
		write_reg(vtpd_pkg::CFG_IDX_W'($urandom_range(vtpd_pkg::REG_CHANNEL_INDEX + 1,
			{vtpd_pkg::CFG_IDX_W{1'b1}})), 8'($urandom));
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [7:0] pick_command();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 8'($urandom_range(0, vtpd_pkg::LEVEL_MAX));
			4: begin
				case ($urandom_range(0, 3))
					0: return 8'd0;
					1: return vtpd_pkg::LEVEL_MAX;
					2: return vtpd_pkg::LEVEL_HALF;
					default: return vtpd_pkg::LEVEL_HALF - 8'd1;
				endcase
			end
			5, 6: begin
				case ($urandom_range(0, 2))
					0: return vtpd_pkg::CODE_TOGGLE;
					1: return vtpd_pkg::CODE_AUTO;
					default: return vtpd_pkg::CODE_MANUAL;
				endcase
			end
			7: return 8'($urandom_range(vtpd_pkg::LEVEL_MAX + 1, vtpd_pkg::UNSET_CODE));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_error_pos();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return vtpd_pkg::LEVEL_MAX;
			2: return vtpd_pkg::LEVEL_MAX + 8'd1;
			3: return vtpd_pkg::UNSET_CODE - 8'd1;
			4: return vtpd_pkg::UNSET_CODE;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	// levels, mode codes, lock and error position handling
	task automatic test_modes();
		gap_pct   = 20;
		stall_pct = 20;
		send_word(vtpd_pkg::REQ_TICK, 8'hA5, 1'b1);
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::LEVEL_MAX, 1'b0);
		send_word(vtpd_pkg::REQ_SET, 8'd0, 1'b0);
		// same level again
		send_word(vtpd_pkg::REQ_SET, 8'd0, 1'b0);
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::CODE_AUTO, 1'b0);
		// plain level in auto falls back to the error position
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::LEVEL_HALF, 1'b0);
		send_word(vtpd_pkg::REQ_SET, 8'd150, 1'b1);
		// unknown code in auto
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::CODE_AUTO + 8'd1, 1'b0);
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::CODE_TOGGLE, 1'b0);
		// unknown code in manual
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::UNSET_CODE, 1'b0);
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::CODE_TOGGLE, 1'b1);
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::CODE_MANUAL, 1'b0);
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::LEVEL_HALF - 8'd1, 1'b0);
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::LEVEL_HALF, 1'b0);
		// locked, error position unset
		configure(8'd0, vtpd_pkg::UNSET_CODE, 1'b0, 1'b0, 3'd3);
		send_word(vtpd_pkg::REQ_SET, 8'd120, 1'b0);
		send_word(vtpd_pkg::REQ_SET, 8'd120, 1'b1);
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::CODE_AUTO, 1'b0);
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::CODE_AUTO, 1'b1);
		send_word(vtpd_pkg::REQ_TICK, 8'h5A, 1'b0);
		// error position above full scale saturates
		configure(vtpd_pkg::UNSET_CODE, 8'd250, 1'b1, 1'b1, 3'd0);
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::CODE_TOGGLE, 1'b0);
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::CODE_AUTO, 1'b0);
		send_word(vtpd_pkg::REQ_SET, vtpd_pkg::CODE_MANUAL, 1'b0);
		send_word(vtpd_pkg::REQ_SET, 8'd1, 1'b0);
	endtask

	// startup delay and the first phase switch for each level and polarity
	task automatic test_pwm_cycle();
		logic [7:0] seg_level[4];
		logic [2:0] chan;
		seg_level = '{vtpd_pkg::LEVEL_MAX, 8'd0, vtpd_pkg::LEVEL_MAX - 8'd1, 8'd1};
		gap_pct   = 10;
		stall_pct = 5;
		configure(8'd1, vtpd_pkg::DEFAULT_ERR, 1'b1, 1'b1, 3'd1);
		tick_run(30);
		// lowering the channel during startup ends the startup phase at once
		configure(8'd1, vtpd_pkg::DEFAULT_ERR, 1'b1, 1'b1, 3'd0);
		tick_run(20);
		// fresh reset each time so the startup switch is seen again
		for (int seg = 0; seg < 4; seg++) begin
			chan = 3'($urandom);
			restart();
			configure(8'd1, vtpd_pkg::DEFAULT_ERR, 1'b1, seg[0], chan);
			send_word(vtpd_pkg::REQ_SET, seg_level[seg], 1'b1);
			tick_run(STARTUP_MS * (int'(chan) + 1) + 20);
		end
	endtask

	// random ticks and commands under a sweep of register settings
	task automatic test_random_mix(int phases, int words, logic quiet);
		for (int p = 0; p < phases; p++) begin
			case (mix_phase)
				0: configure(8'd0, 8'd0, 1'b0, 1'b0, 3'd0);
				1: configure(vtpd_pkg::UNSET_CODE, vtpd_pkg::UNSET_CODE, 1'b1, 1'b1, 3'd7);
				2: configure(8'd1, vtpd_pkg::LEVEL_MAX, 1'b1, 1'b0, 3'd2);
				3: configure(vtpd_pkg::UNSET_CODE - 8'd1, vtpd_pkg::LEVEL_MAX + 8'd1,
					1'b1, 1'b1, 3'd5);
				default: configure(8'($urandom), pick_error_pos(),
					$urandom_range(0, 3) != 0, 1'($urandom), 3'($urandom));
			endcase
			mix_phase++;
			gap_pct   = quiet ? 0 : pick_pct();
			stall_pct = quiet ? 0 : pick_pct();
			repeat (words) begin
				if ($urandom_range(0, 2) == 0)
					send_word(vtpd_pkg::REQ_TICK, 8'($urandom), 1'($urandom));
				else
					send_word(vtpd_pkg::REQ_SET, pick_command(), $urandom_range(0, 9) < 3);
			end
		end
	endtask

	initial begin
		arst_n               <= 1'b0;
		cfg_wr_en            <= 1'b0;
		cfg_index            <= vtpd_pkg::REG_SWITCH_TIME;
		cfg_data             <= 8'd0;
		req_ch.valid         <= 1'b0;
		req_ch.req_type      <= vtpd_pkg::REQ_TICK;
		req_ch.command_value <= 8'd0;
		req_ch.by_pid        <= 1'b0;
		words_sent     = 0;
		words_checked  = 0;
		mismatch_count = 0;
		gap_pct        = 0;
		stall_pct      = 0;
		mix_phase      = 0;
		valve_reset();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_modes();
		test_pwm_cycle();
		test_random_mix(6, 150, 1'b0);
		test_random_mix(1, 150, 1'b1);
		drain();

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
